/* hdl/rkgd_pkg.sv */
// Shared types, codes and reset values for the rotary knob gesture decoder.
package rkgd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int FIELD_W     = 16;
    localparam int EXT_W       = 33;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;
    localparam int KIND_W      = 2;
    localparam int NOW_W       = 32;

    localparam logic [KIND_W-1:0] KIND_ENC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BTN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POLL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_DEB  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_ROT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_DEB  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 3'd4;

    localparam logic [CFG_WIDTH-1:0] ROT_DEB_RST  = 16'd2;
    localparam logic [CFG_WIDTH-1:0] FAST_ROT_RST = 16'd80;
    localparam logic [CFG_WIDTH-1:0] BTN_DEB_RST  = 16'd25;
    localparam logic [CFG_WIDTH-1:0] LONG_RST     = 16'd1200;

    localparam logic signed [EXT_W-1:0] OUT_MAX = 33'sd32767;
    localparam logic signed [EXT_W-1:0] OUT_MIN = -33'sd32768;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] rot_deb;
        logic [CFG_WIDTH-1:0] fast_rot;
        logic [CFG_WIDTH-1:0] btn_deb;
        logic [CFG_WIDTH-1:0] long_ms;
        logic                 reverse;
    } t_cfg;

    typedef struct packed {
        logic               long_press;
        logic               click;
        logic [FIELD_W-1:0] mode_steps;
        logic               accelerated;
        logic [FIELD_W-1:0] value_steps;
    } t_result;

    function automatic logic [FIELD_W-1:0] clamp16(input logic signed [EXT_W-1:0] c);
        logic signed [EXT_W-1:0] v;
        v = c;
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end else if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[FIELD_W-1:0];
    endfunction

endpackage

/* hdl/rotary_knob_gesture_decoder.sv */
// Top level of the rotary knob gesture decoder: input register, core, result register.
// A poll request passes through the input register and then the result register, where
// its result is held until taken; encoder and button requests give no result.
// Throughput: one request per cycle; a poll stalls only while the result register
// is full and not taken. Reset (synchronous, active low) restores default
// configuration, zeroes counts and times, and leaves the button released.
module rotary_knob_gesture_decoder #(
    parameter int COUNT_WIDTH = rkgd_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = rkgd_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [31:0] now_ms, [32] phase_a_level, [33] button_level
    input  logic [rkgd_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [1:0] kind
    input  logic [rkgd_pkg::KIND_W-1:0]       i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [15:0] value_steps, [16] accelerated, [32:17] mode_steps,
    // [33] click, [34] long_press
    output logic [rkgd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [rkgd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rkgd_pkg::CFG_WIDTH-1:0]    i_cfg_data
);
    import rkgd_pkg::*;

    localparam int RES_W = $bits(t_result);

    t_cfg                  cfg;
    t_result               result;

    logic                  r_in_valid;
    logic [KIND_W-1:0]     r_kind;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  r_phase_a;
    logic                  r_button;

    logic                  r_out_valid;
    t_result               r_out;

    logic                  out_free;
    logic                  fire;
    logic                  s_ready;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign fire     = r_in_valid && (out_free || (r_kind != KIND_POLL));
    assign s_ready  = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_axis_tvalid) begin
            r_kind    <= i_s_axis_tuser;
            r_now     <= i_s_axis_tdata[TIME_WIDTH-1:0];
            r_phase_a <= i_s_axis_tdata[NOW_W];
            r_button  <= i_s_axis_tdata[NOW_W+1];
        end
    end

    rkgd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rkgd_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_kind    (r_kind),
        .i_now     (r_now),
        .i_phase_a (r_phase_a),
        .i_button  (r_button),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && (r_kind == KIND_POLL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && fire && (r_kind == KIND_POLL)) begin
            r_out <= result;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, r_out};

endmodule

/* hdl/rkgd_cfg.sv */
// Configuration register file for the knob decoder.
module rkgd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rkgd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rkgd_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    output rkgd_pkg::t_cfg                  o_cfg
);
    import rkgd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_deb  <= ROT_DEB_RST;
            r_cfg.fast_rot <= FAST_ROT_RST;
            r_cfg.btn_deb  <= BTN_DEB_RST;
            r_cfg.long_ms  <= LONG_RST;
            r_cfg.reverse  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROT_DEB:  r_cfg.rot_deb  <= i_cfg_data;
                CFG_FAST_ROT: r_cfg.fast_rot <= i_cfg_data;
                CFG_BTN_DEB:  r_cfg.btn_deb  <= i_cfg_data;
                CFG_LONG:     r_cfg.long_ms  <= i_cfg_data;
                CFG_REVERSE:  r_cfg.reverse  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/rkgd_core.sv */
// Gesture state: debounce, detent counters, press tracking and poll result.
module rkgd_core #(
    parameter int COUNT_WIDTH = rkgd_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = rkgd_pkg::TIME_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [rkgd_pkg::KIND_W-1:0]  i_kind,
    input  logic [TIME_WIDTH-1:0]        i_now,
    input  logic                         i_phase_a,
    input  logic                         i_button,
    input  rkgd_pkg::t_cfg               i_cfg,
    output rkgd_pkg::t_result            o_result
);
    import rkgd_pkg::*;

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    logic [TIME_WIDTH-1:0]         r_last_rot, n_last_rot;
    logic [TIME_WIDTH-1:0]         r_last_btn, n_last_btn;
    logic [TIME_WIDTH-1:0]         r_press_start, n_press_start;
    logic                          r_held, n_held;
    logic                          r_turned, n_turned;
    logic                          r_long_rep, n_long_rep;
    logic signed [COUNT_WIDTH-1:0] r_value, n_value;
    logic signed [COUNT_WIDTH-1:0] r_mode, n_mode;
    logic                          r_accel, n_accel;
    logic                          r_short, n_short;

    logic [TIME_WIDTH-1:0]         gap_rot;
    logic [TIME_WIDTH-1:0]         gap_btn;
    logic [TIME_WIDTH-1:0]         gap_hold;
    logic                          dir_up;
    logic                          long_now;
    logic signed [EXT_W-1:0]       value_ext;
    logic signed [EXT_W-1:0]       mode_ext;
    logic signed [COUNT_WIDTH-1:0] value_step;
    logic signed [COUNT_WIDTH-1:0] mode_step;

    assign gap_rot  = i_now - r_last_rot;
    assign gap_btn  = i_now - r_last_btn;
    assign gap_hold = i_now - r_press_start;
    assign dir_up   = ~i_phase_a ^ i_cfg.reverse;
    assign long_now = r_held && !r_turned && !r_long_rep
                      && (gap_hold >= TIME_WIDTH'(i_cfg.long_ms));

    always_comb begin
        if (dir_up) begin
            value_step = (r_value == CNT_MAX) ? r_value : r_value + COUNT_WIDTH'(1);
            mode_step  = (r_mode == CNT_MAX) ? r_mode : r_mode + COUNT_WIDTH'(1);
        end else begin
            value_step = (r_value == CNT_MIN) ? r_value : r_value - COUNT_WIDTH'(1);
            mode_step  = (r_mode == CNT_MIN) ? r_mode : r_mode - COUNT_WIDTH'(1);
        end
    end

    always_comb begin
        n_last_rot    = r_last_rot;
        n_last_btn    = r_last_btn;
        n_press_start = r_press_start;
        n_held        = r_held;
        n_turned      = r_turned;
        n_long_rep    = r_long_rep;
        n_value       = r_value;
        n_mode        = r_mode;
        n_accel       = r_accel;
        n_short       = r_short;
        case (i_kind)
            KIND_ENC: begin
                if (gap_rot >= TIME_WIDTH'(i_cfg.rot_deb)) begin
                    n_last_rot = i_now;
                    if (gap_rot < TIME_WIDTH'(i_cfg.fast_rot)) begin
                        n_accel = 1'b1;
                    end
                    if (r_held) begin
                        n_mode   = mode_step;
                        n_turned = 1'b1;
                    end else begin
                        n_value = value_step;
                    end
                end
            end
            KIND_BTN: begin
                if (gap_btn >= TIME_WIDTH'(i_cfg.btn_deb)) begin
                    n_last_btn = i_now;
                    if (!i_button && !r_held) begin
                        n_held        = 1'b1;
                        n_turned      = 1'b0;
                        n_long_rep    = 1'b0;
                        n_press_start = i_now;
                    end else if (i_button && r_held) begin
                        n_held = 1'b0;
                        if (!r_long_rep && !r_turned) begin
                            n_short = 1'b1;
                        end
                    end
                end
            end
            KIND_POLL: begin
                n_value    = '0;
                n_mode     = '0;
                n_accel    = 1'b0;
                n_short    = 1'b0;
                n_long_rep = r_long_rep | long_now;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rot    <= '0;
            r_last_btn    <= '0;
            r_press_start <= '0;
            r_held        <= 1'b0;
            r_turned      <= 1'b0;
            r_long_rep    <= 1'b0;
            r_value       <= '0;
            r_mode        <= '0;
            r_accel       <= 1'b0;
            r_short       <= 1'b0;
        end else if (i_fire) begin
            r_last_rot    <= n_last_rot;
            r_last_btn    <= n_last_btn;
            r_press_start <= n_press_start;
            r_held        <= n_held;
            r_turned      <= n_turned;
            r_long_rep    <= n_long_rep;
            r_value       <= n_value;
            r_mode        <= n_mode;
            r_accel       <= n_accel;
            r_short       <= n_short;
        end
    end

    assign value_ext = EXT_W'(r_value);
    assign mode_ext  = EXT_W'(r_mode);

    always_comb begin
        o_result.value_steps = clamp16(value_ext);
        o_result.accelerated = r_accel;
        o_result.mode_steps  = clamp16(mode_ext);
        o_result.click       = r_short;
        o_result.long_press  = long_now;
    end

endmodule

/* test/rkgd_checker.sv */
// Checker for the rotary knob gesture decoder: predicts each poll report and compares it.
`timescale 1ns / 1ps
module rkgd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // [31:0] now_ms, [32] phase_a_level, [33] button_level
    input  logic [rkgd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] kind
    input  logic [rkgd_pkg::KIND_W-1:0]     i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // [15:0] value_steps, [16] accelerated, [32:17] mode_steps,
    // [33] click, [34] long_press
    input  logic [rkgd_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [rkgd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rkgd_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import rkgd_pkg::*;

    localparam logic signed [FIELD_W-1:0] CNT_TOP = 16'sh7FFF;
    localparam logic signed [FIELD_W-1:0] CNT_BOT = 16'sh8000;

    t_cfg                      knob_cfg;
    logic [NOW_W-1:0]          last_turn_ms;
    logic [NOW_W-1:0]          last_btn_ms;
    logic [NOW_W-1:0]          press_start_ms;
    logic                      held;
    logic                      turned_in_hold;
    logic                      long_sent;
    logic                      fast_seen;
    logic                      click_seen;
    logic signed [FIELD_W-1:0] value_cnt;
    logic signed [FIELD_W-1:0] mode_cnt;
    t_result                   poll_reports[$];
    int                        fails = 0;

    function automatic logic signed [FIELD_W-1:0] bump(input logic signed [FIELD_W-1:0] c,
                                                       input logic up);
        if (up) begin
            return (c == CNT_TOP) ? c : c + 16'sd1;
        end
        return (c == CNT_BOT) ? c : c - 16'sd1;
    endfunction

    task automatic knob_step(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] stamp,
                             input logic pa, input logic lvl);
        logic [NOW_W-1:0] gap;
        logic             up;
        t_result          rep;
        gap = stamp - last_turn_ms;
        up = (pa == 1'b0) ^ knob_cfg.reverse;
        rep = '0;
        case (kind)
            KIND_ENC: begin
                if (gap >= knob_cfg.rot_deb) begin
                    if (gap < knob_cfg.fast_rot) begin
                        fast_seen = 1'b1;
                    end
                    last_turn_ms = stamp;
                    if (held) begin
                        mode_cnt = bump(mode_cnt, up);
                        turned_in_hold = 1'b1;
                    end else begin
                        value_cnt = bump(value_cnt, up);
                    end
                end
            end
            KIND_BTN: begin
                if (NOW_W'(stamp - last_btn_ms) >= knob_cfg.btn_deb) begin
                    last_btn_ms = stamp;
                    if (!lvl && !held) begin
                        held = 1'b1;
                        turned_in_hold = 1'b0;
                        long_sent = 1'b0;
                        press_start_ms = stamp;
                    end else if (lvl && held) begin
                        held = 1'b0;
                        if (!long_sent && !turned_in_hold) begin
                            click_seen = 1'b1;
                        end
                    end
                end
            end
            KIND_POLL: begin
                rep.value_steps = value_cnt;
                rep.accelerated = fast_seen;
                rep.mode_steps = mode_cnt;
                rep.click = click_seen;
                rep.long_press = held && !turned_in_hold && !long_sent &&
                                 (NOW_W'(stamp - press_start_ms) >= knob_cfg.long_ms);
                if (rep.long_press) begin
                    long_sent = 1'b1;
                end
                value_cnt = '0;
                mode_cnt = '0;
                fast_seen = 1'b0;
                click_seen = 1'b0;
                poll_reports.push_back(rep);
            end
            default: ;
        endcase
    endtask

    function automatic int field_bad(input string name, input logic signed [31:0] want,
                                     input logic signed [31:0] got);
        if (got === want) begin
            return 0;
        end
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
    endfunction

    task automatic check_report(input t_result got);
        t_result want;
        if (poll_reports.size() == 0) begin
            $error("report %h arrived with no poll outstanding", got);
            fails++;
            return;
        end
        want = poll_reports.pop_front();
        fails += field_bad("value_steps", 32'($signed(want.value_steps)),
                           32'($signed(got.value_steps)));
        fails += field_bad("accelerated", 32'(want.accelerated), 32'(got.accelerated));
        fails += field_bad("mode_steps", 32'($signed(want.mode_steps)),
                           32'($signed(got.mode_steps)));
        fails += field_bad("click", 32'(want.click), 32'(got.click));
        fails += field_bad("long_press", 32'(want.long_press), 32'(got.long_press));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            knob_cfg = '{rot_deb: ROT_DEB_RST, fast_rot: FAST_ROT_RST, btn_deb: BTN_DEB_RST,
                         long_ms: LONG_RST, reverse: 1'b0};
            last_turn_ms = '0;
            last_btn_ms = '0;
            press_start_ms = '0;
            held = 1'b0;
            turned_in_hold = 1'b0;
            long_sent = 1'b0;
            fast_seen = 1'b0;
            click_seen = 1'b0;
            value_cnt = '0;
            mode_cnt = '0;
            poll_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROT_DEB:  knob_cfg.rot_deb = i_cfg_data;
                    CFG_FAST_ROT: knob_cfg.fast_rot = i_cfg_data;
                    CFG_BTN_DEB:  knob_cfg.btn_deb = i_cfg_data;
                    CFG_LONG:     knob_cfg.long_ms = i_cfg_data;
                    CFG_REVERSE:  knob_cfg.reverse = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                knob_step(i_s_tuser, i_s_tdata[NOW_W-1:0], i_s_tdata[32], i_s_tdata[33]);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_report(t_result'(i_m_tdata[$bits(t_result)-1:0]));
            end
        end
        o_fail_count <= fails;
        o_pending <= poll_reports.size();
    end

endmodule

/* test/tb.sv */
// Testbench top for the rotary knob gesture decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import rkgd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int SAT_RUN = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_WIDTH-1:0]  cfg_data = '0;
    int                    fail_count;
    int                    pending;

    logic [NOW_W-1:0]      stamp_ms = '0;
    logic [CFG_WIDTH-1:0]  rot_deb_set = ROT_DEB_RST;
    logic [CFG_WIDTH-1:0]  fast_set = FAST_ROT_RST;
    logic [CFG_WIDTH-1:0]  btn_deb_set = BTN_DEB_RST;
    logic [CFG_WIDTH-1:0]  long_set = LONG_RST;
    int                    burst_left = 0;
    bit                    idle_on = 1'b1;
    int                    sent = 0;
    int                    rx_tick = 0;

    rotary_knob_gesture_decoder u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    rkgd_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // stall the report channel on a slowly rotating pattern
    always @(posedge clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_tick[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (rx_tick[2:0] != 3'd0);
            default: m_tready <= (rx_tick[4:0] >= 5'd24);
        endcase
    end

    task automatic push_req(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] stamp,
                            input logic pa, input logic lvl);
        int pause;
        pause = 0;
        if (idle_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (pause > 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'd0, lvl, pa, stamp};
        do @(posedge clk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end
        sent++;
    endtask

    task automatic turn(input logic [NOW_W-1:0] gap, input logic pa);
        stamp_ms += gap;
        push_req(KIND_ENC, stamp_ms, pa, 1'($urandom_range(0, 1)));
    endtask

    task automatic flip(input logic [NOW_W-1:0] gap, input logic lvl);
        stamp_ms += gap;
        push_req(KIND_BTN, stamp_ms, 1'($urandom_range(0, 1)), lvl);
    endtask

    task automatic poll(input logic [NOW_W-1:0] gap);
        stamp_ms += gap;
        push_req(KIND_POLL, stamp_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // pick a time step around a threshold, hitting both sides of it
    function automatic logic [NOW_W-1:0] near(input logic [NOW_W-1:0] base);
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return (base == 0) ? '0 : base - 1;
            2:       return base;
            3:       return base + 1;
            4:       return $urandom_range(0, base * 2 + 8);
            5:       return $urandom_range(0, 40);
            default: return base + $urandom_range(0, base + 100);
        endcase
    endfunction

    function automatic logic [NOW_W-1:0] turn_gap();
        return ($urandom_range(0, 1) == 0) ? near(NOW_W'(rot_deb_set)) : near(NOW_W'(fast_set));
    endfunction

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic apply_cfg(input logic [CFG_WIDTH-1:0] rd, input logic [CFG_WIDTH-1:0] fr,
                             input logic [CFG_WIDTH-1:0] bd, input logic [CFG_WIDTH-1:0] lp,
                             input logic rev);
        settle();
        set_reg(CFG_ROT_DEB, rd);
        set_reg(CFG_FAST_ROT, fr);
        set_reg(CFG_BTN_DEB, bd);
        set_reg(CFG_LONG, lp);
        set_reg(CFG_REVERSE, {15'd0, rev});
        cfg_we <= 1'b0;
        rot_deb_set = rd;
        fast_set = fr;
        btn_deb_set = bd;
        long_set = lp;
    endtask

    task automatic gesture();
        int   n;
        logic dir;
        n = $urandom_range(1, 10);
        dir = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 6))
            0: begin
                repeat (n) turn(turn_gap(), ($urandom_range(0, 7) == 0) ? !dir : dir);
                poll(near(NOW_W'(fast_set)));
            end
            1: begin
                // press, bounce, release
                flip(near(NOW_W'(btn_deb_set)), 1'b0);
                repeat ($urandom_range(0, 3)) begin
                    flip(near(NOW_W'(btn_deb_set)), 1'($urandom_range(0, 1)));
                end
                flip(near(NOW_W'(btn_deb_set)), 1'b1);
                poll(near(NOW_W'(btn_deb_set)));
            end
            2: begin
                flip(near(NOW_W'(btn_deb_set)), 1'b0);
                repeat (n) turn(turn_gap(), dir);
                flip(near(NOW_W'(btn_deb_set)), 1'b1);
                poll(near(NOW_W'(fast_set)));
            end
            3: begin
                flip(near(NOW_W'(btn_deb_set)), 1'b0);
                repeat ($urandom_range(2, 5)) poll(near(NOW_W'(long_set / 3)));
                if ($urandom_range(0, 3) == 0) begin
                    turn(turn_gap(), dir);
                    poll(near(NOW_W'(long_set / 3)));
                end
                flip(near(NOW_W'(btn_deb_set)), 1'b1);
                poll(near(NOW_W'(btn_deb_set)));
            end
            4: poll(near(NOW_W'(long_set)));
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    push_req(KIND_W'($urandom_range(0, 3)),
                             ($urandom_range(0, 1) == 0) ? $urandom() :
                                                          stamp_ms + $urandom_range(0, 100),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent + count;
        while (sent < target) gesture();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // early stamps, rejected edges and reset defaults
        push_req(KIND_ENC, 32'd0, 1'b0, 1'b0);
        push_req(KIND_ENC, 32'd1, 1'b0, 1'b1);
        push_req(KIND_BTN, 32'd10, 1'b1, 1'b0);
        push_req(KIND_POLL, 32'd20, 1'b0, 1'b1);
        push_req(KIND_ENC, 32'd2, 1'b0, 1'b0);
        push_req(KIND_ENC, 32'd200, 1'b1, 1'b1);
        push_req(KIND_ENC, 32'hFFFF_FFFF, 1'b1, 1'b0);
        push_req(KIND_POLL, 32'd300, 1'b1, 1'b0);
        // press, redundant press, turn while held
        push_req(KIND_BTN, 32'd25, 1'b0, 1'b0);
        push_req(KIND_BTN, 32'd60, 1'b1, 1'b0);
        push_req(KIND_ENC, 32'd1000, 1'b0, 1'b1);
        push_req(KIND_POLL, 32'd1300, 1'b0, 1'b0);
        push_req(KIND_BTN, 32'd1400, 1'b0, 1'b1);
        push_req(KIND_POLL, 32'd1401, 1'b1, 1'b1);
        // long press right at the threshold, reported once
        push_req(KIND_BTN, 32'd1500, 1'b0, 1'b0);
        push_req(KIND_POLL, 32'd2699, 1'b0, 1'b0);
        push_req(KIND_POLL, 32'd2700, 1'b0, 1'b0);
        push_req(KIND_POLL, 32'd2701, 1'b0, 1'b0);
        push_req(KIND_BTN, 32'd2800, 1'b0, 1'b1);
        push_req(KIND_BTN, 32'd2900, 1'b1, 1'b1);
        // clean short press, spare kind ignored
        push_req(KIND_BTN, 32'd3000, 1'b0, 1'b0);
        push_req(KIND_BTN, 32'd3100, 1'b0, 1'b1);
        push_req(KIND_SPARE, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_req(KIND_POLL, 32'd3300, 1'b1, 1'b1);
        stamp_ms = 32'd4000;
        run_random(RANDOM_PER_PHASE);

        // turn both counters back to back without idling
        apply_cfg(16'd0, FAST_ROT_RST, BTN_DEB_RST, LONG_RST, 1'b0);
        idle_on = 1'b0;
        repeat (SAT_RUN) turn('0, 1'b0);
        poll(32'd1);
        flip(32'd100, 1'b0);
        repeat (SAT_RUN) turn('0, 1'b1);
        poll(32'd1);
        flip(32'd100, 1'b1);
        poll(32'd1);
        idle_on = 1'b1;

        apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        run_random(RANDOM_PER_PHASE);

        apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        stamp_ms = 32'hFFF0_0000;
        run_random(RANDOM_PER_PHASE);

        repeat (3) begin
            apply_cfg(CFG_WIDTH'($urandom_range(0, 10)), CFG_WIDTH'($urandom_range(0, 120)),
                      CFG_WIDTH'($urandom_range(0, 40)), CFG_WIDTH'($urandom_range(0, 2000)),
                      1'($urandom_range(0, 1)));
            stamp_ms = 32'hFFFF_FF00;
            run_random(RANDOM_PER_PHASE / 2);
        end

        apply_cfg(CFG_WIDTH'($urandom()), CFG_WIDTH'($urandom()), CFG_WIDTH'($urandom()),
                  CFG_WIDTH'($urandom()), 1'($urandom_range(0, 1)));
        run_random(RANDOM_PER_PHASE);

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
